FILE: rtl/core/grouped_float_min_accumulator_unit_defines.svh
// Assertion macros shared by the grouped minimum accumulator RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef GROUPED_FLOAT_MIN_ACCUMULATOR_UNIT_DEFINES_SVH
`define GROUPED_FLOAT_MIN_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define GFMA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define GFMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/gfma_pkg.sv
// Types, constants and the double compare of the grouped minimum accumulator.
// No dependencies.
package gfma_pkg;

  localparam int GROUPS = 1024;
  localparam int GRP_W  = $clog2(GROUPS);
  localparam int GCNT_W = 11;
  localparam int IDX_W  = 10;
  localparam int DATA_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] NA_PATTERN      = 64'h7FF0_0000_0000_07A2;
  localparam logic [DATA_W-1:0] POS_INF_PATTERN = 64'h7FF0_0000_0000_0000;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_ACC   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIP_MISSING = 2'd0,
    CFG_GROUP_COUNT  = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    req_t req;
    logic ok;
    logic skip;
  } upd_ctl_t;

  function automatic logic is_nan(input logic [DATA_W-1:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != '0);
  endfunction

  // a < b for non-NaN doubles; +0 and -0 compare equal.
  function automatic logic dbl_less(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    logic res;
    if (a[62:0] == '0 && b[62:0] == '0) res = 1'b0;
    else if (a[63] != b[63]) res = a[63];
    else if (!a[63]) res = a[62:0] < b[62:0];
    else res = a[62:0] > b[62:0];
    return res;
  endfunction

endpackage

FILE: rtl/core/gfma_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds when no read is issued.
module gfma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/gfma_update.sv
// Read-modify-write logic for one group entry: new minimum and read value.
// Depends on gfma_pkg.
module gfma_update import gfma_pkg::*; (
  input  upd_ctl_t          ctl,
  input  logic              entry_seen,
  input  logic [DATA_W-1:0] entry_min,
  input  logic [DATA_W-1:0] x,
  output logic              wr,
  output logic [DATA_W-1:0] wr_min,
  output logic [DATA_W-1:0] rd_val
);
  logic xnan;
  logic hnan;

  assign xnan = is_nan(x);
  assign hnan = is_nan(entry_min);
  assign wr_min = x;

  always_comb begin
    wr = 1'b0;
    if (ctl.req == REQ_ACC && ctl.ok && !(ctl.skip && xnan)) begin
      if (!entry_seen) wr = 1'b1;
      else if (hnan) wr = ctl.skip;
      else if (xnan) wr = 1'b1;
      else wr = dbl_less(x, entry_min);
    end
  end

  assign rd_val = (ctl.ok && entry_seen) ? entry_min
                : (ctl.skip ? NA_PATTERN : POS_INF_PATTERN);
endmodule

FILE: rtl/core/grouped_float_min_accumulator_unit.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_stall   | req_type, group_index, sample_bits
// out     | output    | out_valid/out_stall | result_group, min_bits
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An accumulate or read transaction reads the table on accept in S_IDLE,
// then compares and writes back in S_LOOKUP; a new item is taken only once
// the last one is through. A start transaction and reset both run a clearing
// pass over all GROUPS (1024) table entries, during which in_stall is high.
// A read result waits in the output register while out_stall is high.
// Depends on gfma_pkg, gfma_ram, gfma_update and the defines header.
`include "grouped_float_min_accumulator_unit_defines.svh"

module grouped_float_min_accumulator_unit import gfma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [IDX_W-1:0]     group_index,
  input  logic [DATA_W-1:0]    sample_bits,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     result_group,
  output logic [DATA_W-1:0]    min_bits,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GCNT_W-1:0]    cfg_data
);
  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOKUP} state_t;

  state_t            state;
  logic [GRP_W-1:0]  clr_cnt;
  logic              skip_missing;
  logic [GCNT_W-1:0] group_count;

  req_t              cur_req;
  logic              cur_ok;
  logic [GRP_W-1:0]  cur_slot;
  logic [IDX_W-1:0]  cur_group;
  logic [DATA_W-1:0] cur_x;

  logic              accept;
  req_t              in_req;
  logic              in_ok;
  logic [GRP_W-1:0]  in_slot;
  logic              out_free;

  logic              mem_we;
  logic [GRP_W-1:0]  mem_waddr;
  logic [DATA_W:0]   mem_wdata;
  logic [DATA_W:0]   mem_rdata;

  upd_ctl_t          ctl;
  logic              upd_wr;
  logic [DATA_W-1:0] upd_min;
  logic [DATA_W-1:0] upd_rd;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_req    = req_t'(req_type);
  assign out_free  = !out_valid || !out_stall;

  // Group count of zero folds everything into group 0.
  assign in_ok   = (group_count == '0) || ({1'b0, group_index} < group_count);
  assign in_slot = (group_count == '0) ? '0 : GRP_W'(group_index);

  assign ctl = '{req: cur_req, ok: cur_ok, skip: skip_missing};

  gfma_update u_update (
    .ctl        (ctl),
    .entry_seen (mem_rdata[DATA_W]),
    .entry_min  (mem_rdata[DATA_W-1:0]),
    .x          (cur_x),
    .wr         (upd_wr),
    .wr_min     (upd_min),
    .rd_val     (upd_rd)
  );

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == S_LOOKUP) && upd_wr;
      mem_waddr = cur_slot;
      mem_wdata = {1'b1, upd_min};
    end
  end

  gfma_ram #(.WIDTH(DATA_W + 1), .DEPTH(GROUPS)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_slot),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_missing <= 1'b1;
      group_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SKIP_MISSING) skip_missing <= cfg_data[0];
      else if (cfg_index == CFG_GROUP_COUNT) group_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) out_valid <= (state == S_LOOKUP) && (cur_req == REQ_READ);
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == GRP_W'(GROUPS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cur_req   <= in_req;
            cur_ok    <= in_ok;
            cur_slot  <= in_slot;
            cur_group <= (group_count == '0) ? '0 : group_index;
            cur_x     <= sample_bits;
            if (in_req == REQ_START) begin
              state   <= S_CLEAR;
              clr_cnt <= '0;
            end else if (in_req == REQ_ACC || in_req == REQ_READ) begin
              state <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          if (cur_req == REQ_READ) begin
            if (out_free) begin
              result_group <= cur_group;
              min_bits     <= upd_rd;
              state        <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GFMA_ASSERT_IMPLY(a_accept_idle, accept, state == S_IDLE)
  `GFMA_ASSERT_IMPLY(a_write_source, mem_we && state != S_CLEAR,
                     cur_req == REQ_ACC && cur_ok)
  `GFMA_ASSERT_NEXT(a_start_clears, accept && in_req == REQ_START,
                    state == S_CLEAR && clr_cnt == '0)
endmodule
